>>> rtl/gna_pkg.sv
// Shared types, codes and constants of the group norm accumulator.
package gna_pkg;

    // Default sizes
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF    = 48;

    // Fixed formats
    localparam int          LOG_FRAC   = 24;
    localparam int          OUT_W      = 32;
    localparam int          WEIGHT_W   = 16;
    localparam logic [15:0] ONE_Q12    = 16'd4096;

    // Configuration port
    localparam int          CFG_IDX_W  = 3;
    localparam int          CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_WEIGHTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P_EXP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_P_EXP   = 3'd4;
    localparam logic [15:0]          P_EXP_RESET     = 16'd4096;

    // Norm kinds
    typedef enum logic [1:0] {
        KIND_SUM   = 2'd0,
        KIND_RSS   = 2'd1,
        KIND_MAX   = 2'd2,
        KIND_PNORM = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        cplx;
        logic        use_w;
        logic [15:0] p_exp;
        logic [15:0] inv_p_exp;
    } t_cfg;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ABS,
        ST_SQR,
        ST_SQI,
        ST_MAG,
        ST_MAGW,
        ST_PREP,
        ST_WMUL,
        ST_ACC,
        ST_FIN,
        ST_FROOT,
        ST_LNORM,
        ST_LSQ,
        ST_LMUL,
        ST_PINIT,
        ST_PSTEP,
        ST_PWAIT,
        ST_PSCALE,
        ST_OUT
    } t_state;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ABS,
        OP_SQR,
        OP_SQI,
        OP_MAG_REAL,
        OP_MAG_SQRT,
        OP_MAG_TAKE,
        OP_ZERO_TERM,
        OP_WMUL,
        OP_ACC,
        OP_ROOT_START,
        OP_ROOT_TAKE,
        OP_FIN_DIRECT,
        OP_LOG_LOAD,
        OP_LOG_NORM,
        OP_LOG_SQ,
        OP_LOG_MUL,
        OP_POW_INIT,
        OP_POW_STEP,
        OP_POW_TAKE,
        OP_POW_SCALE,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic fin;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  cplx;
        logic  item_last;
        logic  mag_zero;
        logic  ps_zero;
        logic  norm_ok;
        logic  log_last;
        logic  pow_last;
        logic  sqrt_done;
        logic  out_free;
    } t_sts;

endpackage

>>> rtl/gna_isqrt.sv
// Iterative floor square root of a 64-bit radicand, one root bit per cycle.
module gna_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_src;
    logic [33:0] r_rem;
    logic [31:0] r_root;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    // Restoring step on the next two radicand bits
    assign rem_sh = {r_rem, r_src[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_src  <= {r_src[61:0], 2'b00};
            r_rem  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("square root restarted while busy");

endmodule

>>> rtl/gna_dp.sv
// Datapath: magnitude, weighting, log2/exp2 power, accumulator and result register.
module gna_dp #(
    parameter int SAMPLE_WIDTH = gna_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = gna_pkg::ACC_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gna_pkg::t_cmd           i_cmd,
    output gna_pkg::t_sts           o_sts,
    input  gna_pkg::t_cfg           i_cfg,
    input  logic [SAMPLE_WIDTH-1:0] i_re,
    input  logic [SAMPLE_WIDTH-1:0] i_im,
    input  logic [15:0]             i_weight,
    input  logic                    i_last,
    input  logic                    i_m_tready,
    output logic                    o_m_tvalid,
    output logic [31:0]             o_norm,
    output logic                    o_sat
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int AW     = ACC_WIDTH;
    localparam int FB     = SW - 1;
    localparam int MAG_SH = 32 - SW;
    localparam int RAD_SH = 64 - 2 * SW;
    localparam int SQ_SHL = (2 * FB >= 32) ? 0 : 32 - 2 * FB;
    localparam int SQ_SHR = (2 * FB >= 32) ? 2 * FB - 32 : 0;
    localparam logic [AW-1:0] ACC_MAX  = '1;
    localparam logic [4:0]    STEP_END = 5'(gna_pkg::LOG_FRAC - 1);

    // Item and per-element registers
    logic [SW-1:0] r_re, r_im, r_ar, r_ai;
    logic [15:0]   r_w;
    logic          r_last;
    logic [63:0]   r_sumsq;
    logic [31:0]   r_mag;
    logic [53:0]   r_term;
    logic [AW-1:0] r_ps;
    logic          r_ovf;

    // log2 / exp2 registers
    logic [63:0]        r_nv;
    logic [5:0]         r_k;
    logic [31:0]        r_y;
    logic [23:0]        r_frac;
    logic [4:0]         r_cnt;
    logic signed [36:0] r_e;
    logic [31:0]        r_r;
    logic [4:0]         r_j;
    logic [63:0]        r_res;
    logic               r_rsat;

    // Result register
    logic        r_ov;
    logic [31:0] r_norm;
    logic        r_osat;

    gna_pkg::t_op op;
    logic         fin;
    assign op  = i_cmd.op;
    assign fin = i_cmd.fin;

    // Absolute values
    logic [SW-1:0] re_abs, im_abs;
    assign re_abs = r_re[SW-1] ? (~r_re + 1'b1) : r_re;
    assign im_abs = r_im[SW-1] ? (~r_im + 1'b1) : r_im;

    // Shared squarer
    logic [31:0] sq_in;
    logic [63:0] sq_prod;
    always_comb begin
        unique case (op)
            gna_pkg::OP_SQI:    sq_in = 32'(r_ai);
            gna_pkg::OP_LOG_SQ: sq_in = r_y;
            default:            sq_in = 32'(r_ar);
        endcase
    end
    assign sq_prod = 64'(sq_in) * 64'(sq_in);

    // Weight multiplier
    logic [63:0] sq32;
    logic [48:0] wx;
    logic [15:0] w_sel;
    logic [64:0] wprod;
    assign sq32  = (r_sumsq >> SQ_SHR) << SQ_SHL;
    assign w_sel = i_cfg.use_w ? r_w : gna_pkg::ONE_Q12;
    always_comb begin
        unique case (i_cfg.kind)
            gna_pkg::KIND_RSS:   wx = sq32[48:0];
            gna_pkg::KIND_PNORM: wx = r_res[48:0];
            default:             wx = 49'(r_mag);
        endcase
    end
    assign wprod = 65'(wx) * 65'(w_sel);

    // Accumulate
    logic [AW-1:0] tclip;
    logic          clip;
    logic [AW:0]   sum;
    assign clip  = 64'(r_term) > 64'(ACC_MAX);
    assign tclip = clip ? ACC_MAX : AW'(r_term);
    assign sum   = (AW + 1)'(r_ps) + (AW + 1)'(tclip);

    // Log2 fraction step
    logic [32:0] lt;
    assign lt = sq_prod[63:31];

    // Log2 times exponent
    logic signed [7:0]  lint;
    logic signed [31:0] lval;
    logic signed [16:0] qs;
    logic signed [48:0] eprod;
    assign lint  = $signed({2'b00, r_k}) - (fin ? 8'sd32 : 8'sd31);
    assign lval  = {lint, r_frac};
    assign qs    = $signed({1'b0, fin ? i_cfg.inv_p_exp : i_cfg.p_exp});
    assign eprod = lval * qs;

    // Exp2 root chain and final scaling
    logic [23:0]        ef;
    logic [32:0]        rd;
    logic signed [13:0] s_amt;
    logic signed [13:0] ns;
    logic [63:0]        lim;
    logic [63:0]        shl;
    assign ef    = r_e[23:0];
    assign rd    = ef[r_j] ? {r_r, 1'b0} : {1'b0, r_r};
    assign s_amt = {r_e[36], r_e[36:24]} + (fin ? -14'sd14 : 14'sd2);
    assign ns    = -s_amt;
    assign lim   = fin ? 64'h0000_0000_FFFF_FFFF : 64'h0001_0000_0000_0000;
    assign shl   = 64'(r_r) << s_amt[5:0];

    // Square root unit, shared by magnitude, exp2 steps and the final root
    logic        sq_start;
    logic [63:0] sq_rad;
    logic        sq_done;
    logic [31:0] sq_root;
    always_comb begin
        sq_start = 1'b0;
        sq_rad   = 64'(r_ps);
        unique case (op)
            gna_pkg::OP_MAG_SQRT: begin
                sq_start = 1'b1;
                sq_rad   = r_sumsq << RAD_SH;
            end
            gna_pkg::OP_POW_STEP: begin
                sq_start = 1'b1;
                sq_rad   = {1'b0, rd, 30'd0};
            end
            gna_pkg::OP_ROOT_START: sq_start = 1'b1;
            default: ;
        endcase
    end

    gna_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // Control state: accumulator, overflow flag, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps  <= '0;
            r_ovf <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (op == gna_pkg::OP_ACC) begin
                if (i_cfg.kind == gna_pkg::KIND_MAX) begin
                    if (tclip > r_ps) r_ps <= tclip;
                    if (clip) r_ovf <= 1'b1;
                end else if (64'(r_term) > 64'(ACC_MAX) || sum > (AW + 1)'(ACC_MAX)) begin
                    r_ps  <= ACC_MAX;
                    r_ovf <= 1'b1;
                end else begin
                    r_ps <= sum[AW-1:0];
                end
            end else if (op == gna_pkg::OP_OUT) begin
                r_ps  <= '0;
                r_ovf <= 1'b0;
            end
            if (op == gna_pkg::OP_OUT) r_ov <= 1'b1;
            else if (i_m_tready) r_ov <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        unique case (op)
            gna_pkg::OP_LOAD: begin
                r_re   <= i_re;
                r_im   <= i_im;
                r_w    <= i_weight;
                r_last <= i_last;
            end
            gna_pkg::OP_ABS: begin
                r_ar <= re_abs;
                r_ai <= i_cfg.cplx ? im_abs : '0;
            end
            gna_pkg::OP_SQR:       r_sumsq <= sq_prod;
            gna_pkg::OP_SQI:       r_sumsq <= r_sumsq + sq_prod;
            gna_pkg::OP_MAG_REAL:  r_mag <= 32'(r_ar) << MAG_SH;
            gna_pkg::OP_MAG_TAKE:  r_mag <= sq_root;
            gna_pkg::OP_ZERO_TERM: r_term <= '0;
            gna_pkg::OP_WMUL: begin
                if (i_cfg.kind == gna_pkg::KIND_SUM || i_cfg.kind == gna_pkg::KIND_MAX)
                    r_term <= 54'(wprod >> 11);
                else
                    r_term <= 54'(wprod >> 12);
            end
            gna_pkg::OP_ROOT_TAKE: begin
                r_res  <= 64'(sq_root);
                r_rsat <= 1'b0;
            end
            gna_pkg::OP_FIN_DIRECT: begin
                r_res  <= 64'(r_ps >> 16);
                r_rsat <= 1'b0;
            end
            gna_pkg::OP_LOG_LOAD: begin
                r_nv <= fin ? 64'(r_ps) : 64'(r_mag);
                r_k  <= 6'd63;
            end
            gna_pkg::OP_LOG_NORM: begin
                if (r_nv[63]) begin
                    r_y    <= r_nv[63:32];
                    r_frac <= '0;
                    r_cnt  <= '0;
                end else if (r_nv[63:56] == 8'd0) begin
                    r_nv <= r_nv << 8;
                    r_k  <= r_k - 6'd8;
                end else begin
                    r_nv <= r_nv << 1;
                    r_k  <= r_k - 6'd1;
                end
            end
            gna_pkg::OP_LOG_SQ: begin
                r_cnt <= r_cnt + 5'd1;
                if (lt[32]) begin
                    r_frac <= {r_frac[22:0], 1'b1};
                    r_y    <= lt[32:1];
                end else begin
                    r_frac <= {r_frac[22:0], 1'b0};
                    r_y    <= lt[31:0];
                end
            end
            gna_pkg::OP_LOG_MUL: r_e <= eprod[48:12];
            gna_pkg::OP_POW_INIT: begin
                r_r <= 32'h4000_0000;
                r_j <= '0;
            end
            gna_pkg::OP_POW_TAKE: begin
                r_r <= sq_root;
                r_j <= r_j + 5'd1;
            end
            gna_pkg::OP_POW_SCALE: begin
                if (!s_amt[13]) begin
                    if (s_amt > 14'sd32 || shl > lim) begin
                        r_res  <= lim;
                        r_rsat <= 1'b1;
                    end else begin
                        r_res  <= shl;
                        r_rsat <= 1'b0;
                    end
                end else begin
                    r_rsat <= 1'b0;
                    r_res  <= (ns > 14'sd31) ? 64'd0 : 64'(r_r >> ns[4:0]);
                end
            end
            gna_pkg::OP_OUT: begin
                r_norm <= (|r_res[63:32]) ? 32'hFFFF_FFFF : r_res[31:0];
                r_osat <= r_ovf | r_rsat | (|r_res[63:32]);
            end
            default: ;
        endcase
    end

    // Status to the controller
    always_comb begin
        o_sts.kind      = i_cfg.kind;
        o_sts.cplx      = i_cfg.cplx;
        o_sts.item_last = r_last;
        o_sts.mag_zero  = (r_mag == 32'd0);
        o_sts.ps_zero   = (r_ps == '0);
        o_sts.norm_ok   = r_nv[63];
        o_sts.log_last  = (r_cnt == STEP_END);
        o_sts.pow_last  = (r_j == STEP_END);
        o_sts.sqrt_done = sq_done;
        o_sts.out_free  = !r_ov || i_m_tready;
    end

    assign o_m_tvalid = r_ov;
    assign o_norm     = r_norm;
    assign o_sat      = r_osat;

    a_ovf_pins_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_ps == ACC_MAX))
        else $error("overflow flagged but accumulator not at maximum");

    a_log_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == gna_pkg::OP_LOG_SQ) |-> r_y[31])
        else $error("log2 mantissa lost normalization");

endmodule

>>> rtl/gna_ctrl.sv
// Controller: sequences one element and the end-of-group root over the datapath.
module gna_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  gna_pkg::t_sts i_sts,
    output gna_pkg::t_cmd o_cmd
);

    gna_pkg::t_state r_state, n_state;
    logic            r_fin, n_fin;
    gna_pkg::t_op    op;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gna_pkg::ST_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_fin      = r_fin;
        op         = gna_pkg::OP_NONE;
        o_s_tready = 1'b0;
        unique case (r_state)
            gna_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                n_fin      = 1'b0;
                if (i_s_tvalid) begin
                    op      = gna_pkg::OP_LOAD;
                    n_state = gna_pkg::ST_ABS;
                end
            end
            gna_pkg::ST_ABS: begin
                op      = gna_pkg::OP_ABS;
                n_state = gna_pkg::ST_SQR;
            end
            gna_pkg::ST_SQR: begin
                op      = gna_pkg::OP_SQR;
                n_state = gna_pkg::ST_SQI;
            end
            gna_pkg::ST_SQI: begin
                op      = gna_pkg::OP_SQI;
                n_state = gna_pkg::ST_MAG;
            end
            gna_pkg::ST_MAG: begin
                if (i_sts.cplx) begin
                    op      = gna_pkg::OP_MAG_SQRT;
                    n_state = gna_pkg::ST_MAGW;
                end else begin
                    op      = gna_pkg::OP_MAG_REAL;
                    n_state = gna_pkg::ST_PREP;
                end
            end
            gna_pkg::ST_MAGW: begin
                if (i_sts.sqrt_done) begin
                    op      = gna_pkg::OP_MAG_TAKE;
                    n_state = gna_pkg::ST_PREP;
                end
            end
            gna_pkg::ST_PREP: begin
                if (i_sts.kind != gna_pkg::KIND_PNORM) begin
                    n_state = gna_pkg::ST_WMUL;
                end else if (i_sts.mag_zero) begin
                    op      = gna_pkg::OP_ZERO_TERM;
                    n_state = gna_pkg::ST_ACC;
                end else begin
                    op      = gna_pkg::OP_LOG_LOAD;
                    n_state = gna_pkg::ST_LNORM;
                end
            end
            gna_pkg::ST_WMUL: begin
                op      = gna_pkg::OP_WMUL;
                n_state = gna_pkg::ST_ACC;
            end
            gna_pkg::ST_ACC: begin
                op = gna_pkg::OP_ACC;
                if (i_sts.item_last) begin
                    n_state = gna_pkg::ST_FIN;
                    n_fin   = 1'b1;
                end else begin
                    n_state = gna_pkg::ST_IDLE;
                end
            end
            gna_pkg::ST_FIN: begin
                priority if (i_sts.kind == gna_pkg::KIND_RSS) begin
                    op      = gna_pkg::OP_ROOT_START;
                    n_state = gna_pkg::ST_FROOT;
                end else if (i_sts.kind == gna_pkg::KIND_PNORM && !i_sts.ps_zero) begin
                    op      = gna_pkg::OP_LOG_LOAD;
                    n_state = gna_pkg::ST_LNORM;
                end else begin
                    op      = gna_pkg::OP_FIN_DIRECT;
                    n_state = gna_pkg::ST_OUT;
                end
            end
            gna_pkg::ST_FROOT: begin
                if (i_sts.sqrt_done) begin
                    op      = gna_pkg::OP_ROOT_TAKE;
                    n_state = gna_pkg::ST_OUT;
                end
            end
            gna_pkg::ST_LNORM: begin
                op = gna_pkg::OP_LOG_NORM;
                if (i_sts.norm_ok) n_state = gna_pkg::ST_LSQ;
            end
            gna_pkg::ST_LSQ: begin
                op = gna_pkg::OP_LOG_SQ;
                if (i_sts.log_last) n_state = gna_pkg::ST_LMUL;
            end
            gna_pkg::ST_LMUL: begin
                op      = gna_pkg::OP_LOG_MUL;
                n_state = gna_pkg::ST_PINIT;
            end
            gna_pkg::ST_PINIT: begin
                op      = gna_pkg::OP_POW_INIT;
                n_state = gna_pkg::ST_PSTEP;
            end
            gna_pkg::ST_PSTEP: begin
                op      = gna_pkg::OP_POW_STEP;
                n_state = gna_pkg::ST_PWAIT;
            end
            gna_pkg::ST_PWAIT: begin
                if (i_sts.sqrt_done) begin
                    op      = gna_pkg::OP_POW_TAKE;
                    n_state = i_sts.pow_last ? gna_pkg::ST_PSCALE : gna_pkg::ST_PSTEP;
                end
            end
            gna_pkg::ST_PSCALE: begin
                op      = gna_pkg::OP_POW_SCALE;
                n_state = r_fin ? gna_pkg::ST_OUT : gna_pkg::ST_WMUL;
            end
            gna_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    op      = gna_pkg::OP_OUT;
                    n_state = gna_pkg::ST_IDLE;
                end
            end
            default: n_state = gna_pkg::ST_IDLE;
        endcase
    end

    assign o_cmd.op  = op;
    assign o_cmd.fin = r_fin;

    a_out_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gna_pkg::ST_OUT) |-> r_fin)
        else $error("result stage reached outside end of group");

    a_sqrt_done_awaited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.sqrt_done |-> (r_state == gna_pkg::ST_MAGW || r_state == gna_pkg::ST_PWAIT
                             || r_state == gna_pkg::ST_FROOT))
        else $error("square root finished with nobody waiting");

endmodule

>>> rtl/group_norm_accumulator.sv
// Group norm accumulator: takes the elements of a group and returns its weighted norm.
// Each element is taken in IDLE and then worked through the datapath before the next
// is accepted. A real element in sum, root-sum-square or max mode passes through ABS,
// SQR, SQI, MAG, PREP, WMUL and ACC. A complex element also waits in MAGW on the
// magnitude square root. In p-norm mode an element with nonzero magnitude runs the
// log2 normalize and squaring steps and 24 exp2 steps on the shared square root unit.
// At the element marked last, the group result passes FIN and then OUT in sum and max
// mode, waits on the square root in FROOT in root-sum-square mode and runs the log2/exp2
// chain in p-norm mode with a nonzero sum. The finished result sits in an output register,
// so the next group can start while it waits to be taken.
module group_norm_accumulator #(
    parameter int SAMPLE_WIDTH = gna_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = gna_pkg::ACC_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Element input
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [((2*SAMPLE_WIDTH+16+7)/8)*8-1:0] i_s_tdata, // re_part, im_part, weight
    input  logic                             i_s_tlast,
    // Norm output
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [31:0]                      o_m_tdata,  // norm_value
    output logic                             o_m_tuser,  // saturated
    // Configuration writes
    input  logic                             i_cfg_we,
    input  logic [gna_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gna_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SW = SAMPLE_WIDTH;

    gna_pkg::t_cfg r_cfg;
    gna_pkg::t_cmd cmd;
    gna_pkg::t_sts sts;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind      <= gna_pkg::KIND_SUM;
            r_cfg.cplx      <= 1'b0;
            r_cfg.use_w     <= 1'b0;
            r_cfg.p_exp     <= gna_pkg::P_EXP_RESET;
            r_cfg.inv_p_exp <= gna_pkg::P_EXP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gna_pkg::CFG_NORM_KIND:   r_cfg.kind      <= gna_pkg::t_kind'(i_cfg_data[1:0]);
                gna_pkg::CFG_COMPLEX:     r_cfg.cplx      <= i_cfg_data[0];
                gna_pkg::CFG_USE_WEIGHTS: r_cfg.use_w     <= i_cfg_data[0];
                gna_pkg::CFG_P_EXP:       r_cfg.p_exp     <= i_cfg_data;
                gna_pkg::CFG_INV_P_EXP:   r_cfg.inv_p_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gna_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg      (r_cfg),
        .i_re       (i_s_tdata[SW-1:0]),
        .i_im       (i_s_tdata[2*SW-1:SW]),
        .i_weight   (i_s_tdata[2*SW+15:2*SW]),
        .i_last     (i_s_tlast),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_norm     (o_m_tdata),
        .o_sat      (o_m_tuser)
    );

endmodule
